// ===== sv/riff_wav_header_parser_unit_assert.svh =====
// Assertion macros shared by the RIFF/WAVE header parser RTL.
`ifndef RIFF_WAV_HEADER_PARSER_UNIT_ASSERT_SVH
`define RIFF_WAV_HEADER_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define RWHP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define RWHP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rwhp_pkg.sv =====
// Types, constants and helper functions of the RIFF/WAVE header parser.
`timescale 1ns / 1ps

package rwhp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
  localparam logic [15:0] FORMAT_PCM   = 16'd1;
  localparam int unsigned OUT_BITS     = 130;
  localparam int unsigned OUT_TDATA_W  = 136;

  typedef enum logic [3:0] {
    PH_FILE = 4'b0001,
    PH_HDR  = 4'b0010,
    PH_PAY  = 4'b0100,
    PH_PAD  = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_FMT   = 2'd1,
    KIND_DATA  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TRUNC   = 2'd1,
    ST_UNSUP   = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_CHANNELS = 2'd0,
    REG_RATE     = 2'd1,
    REG_BITS     = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] sample_width;
    logic [31:0] rate_hz;
    logic [15:0] channels;
    logic [31:0] pay_length;
    logic [31:0] pay_offset;
    status_e     status;
  } result_t;

  function automatic logic [31:0] put_byte(logic [31:0] v, logic [1:0] lane, logic [7:0] b);
    logic [31:0] r;
    r = v;
    for (int i = 0; i < 4; i++) begin
      if (lane == 2'(i)) begin
        r[8*i +: 8] = b;
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] tag_byte(logic [31:0] tag, logic [1:0] lane);
    return tag[8*lane +: 8];
  endfunction

endpackage

// ===== sv/riff_wav_header_parser_unit.sv =====
// Top level of the RIFF/WAVE header parser: byte-serial chunk walker with result register.
`timescale 1ns / 1ps
//
// The block reads a WAV file one byte per transfer on the s_axis channel, with
// s_axis_tlast set on the final byte of the file. Each byte updates the parse
// state in the cycle it is accepted, so one byte is taken every clock cycle while
// s_axis_tready is high. Bytes other than the last give no result. The last byte
// gives one result transfer on m_axis, presented in the cycle after that byte is
// accepted: the status and, when the status is OK, the data offset and size and
// the channel count, sample rate and bits per sample of the last fmt chunk.
// The result waits in an output register; the next file's bytes are accepted
// while it waits unless the register is full and m_axis_tready is low, in
// which case s_axis_tready drops until the result is taken.
// The user must set the three expected values through the cfg write port only
// while no file is in progress; the block does not enforce this. Reset clears
// the parse state and loads 1 channel, 16000 Hz and 16 bits as expected values.
// Each last byte resets the parse state and the next byte starts a new file.

`include "riff_wav_header_parser_unit_assert.svh"

module riff_wav_header_parser_unit #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,   // [7:0] byte_value
  input  logic                               s_axis_tlast,   // last_byte
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [1:0] status, [33:2] pay_offset, [65:34] pay_length, [81:66] channels,
  // [113:82] rate_hz, [129:114] sample_width, [135:130] zero
  output logic [rwhp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [31:0]                        cfg_wdata_i
);

  logic [15:0] exp_channels_q;
  logic [31:0] exp_rate_q;
  logic [15:0] exp_bits_q;

  logic [COUNT_BITS-1:0] pos_q, pos_d;
  rwhp_pkg::phase_e      phase_q, phase_d;
  logic [2:0]            hdr_idx_q, hdr_idx_d;
  logic [31:0]           tag_q, tag_d;
  logic [31:0]           len_q, len_d;
  logic [31:0]           left_q, left_d;
  logic [4:0]            fmt_pos_q, fmt_pos_d;
  rwhp_pkg::kind_e       kind_q, kind_d;
  logic [15:0]           fmt_code_q, fmt_code_d;
  logic [15:0]           chan_q, chan_d;
  logic [31:0]           rate_q, rate_d;
  logic [15:0]           bits_q, bits_d;
  logic                  fmt_seen_q, fmt_seen_d;
  logic                  data_seen_q, data_seen_d;
  logic [COUNT_BITS-1:0] data_start_q, data_start_d;
  logic [31:0]           data_len_q, data_len_d;
  rwhp_pkg::status_e     err_code_q, err_code_d;
  logic                  err_seen_q, err_seen_d;
  logic                  magic_bad_q, magic_bad_d;

  logic                  m_valid_q, m_valid_d;
  rwhp_pkg::result_t     res_q, res_d;

  logic                  in_xfer;
  logic                  last_xfer;
  logic [7:0]            b;
  logic [31:0]           tag_w, len_w;
  logic [31:0]           left_dec;
  rwhp_pkg::status_e     status;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign last_xfer     = in_xfer && s_axis_tlast;
  assign b             = s_axis_tdata;
  assign left_dec      = (left_q != 32'd0) ? (left_q - 32'd1) : left_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_channels_q <= 16'd1;
      exp_rate_q     <= 32'd16000;
      exp_bits_q     <= 16'd16;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rwhp_pkg::REG_CHANNELS: exp_channels_q <= cfg_wdata_i[15:0];
        rwhp_pkg::REG_RATE:     exp_rate_q     <= cfg_wdata_i;
        rwhp_pkg::REG_BITS:     exp_bits_q     <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_d        = pos_q;
    phase_d      = phase_q;
    hdr_idx_d    = hdr_idx_q;
    tag_d        = tag_q;
    len_d        = len_q;
    left_d       = left_q;
    fmt_pos_d    = fmt_pos_q;
    kind_d       = kind_q;
    fmt_code_d   = fmt_code_q;
    chan_d       = chan_q;
    rate_d       = rate_q;
    bits_d       = bits_q;
    fmt_seen_d   = fmt_seen_q;
    data_seen_d  = data_seen_q;
    data_start_d = data_start_q;
    data_len_d   = data_len_q;
    err_code_d   = err_code_q;
    err_seen_d   = err_seen_q;
    magic_bad_d  = magic_bad_q;
    tag_w        = (hdr_idx_q == 3'd0) ? 32'd0 : tag_q;
    len_w        = (hdr_idx_q == 3'd0) ? 32'd0 : len_q;

    if (in_xfer) begin
      pos_d = pos_q + COUNT_BITS'(1);
      if (!err_seen_q) begin
        case (phase_q)
          rwhp_pkg::PH_FILE: begin
            if (pos_q < COUNT_BITS'(4) &&
                b != rwhp_pkg::tag_byte(rwhp_pkg::TAG_RIFF, pos_q[1:0])) begin
              magic_bad_d = 1'b1;
            end
            if (pos_q >= COUNT_BITS'(8) && pos_q < COUNT_BITS'(12) &&
                b != rwhp_pkg::tag_byte(rwhp_pkg::TAG_WAVE, pos_q[1:0])) begin
              magic_bad_d = 1'b1;
            end
            if (pos_q >= COUNT_BITS'(11)) begin
              if (magic_bad_d) begin
                err_code_d = rwhp_pkg::ST_UNSUP;
                err_seen_d = 1'b1;
              end else begin
                phase_d   = rwhp_pkg::PH_HDR;
                hdr_idx_d = 3'd0;
              end
            end
          end
          rwhp_pkg::PH_HDR: begin
            if (!hdr_idx_q[2]) begin
              tag_w = rwhp_pkg::put_byte(tag_w, hdr_idx_q[1:0], b);
            end else begin
              len_w = rwhp_pkg::put_byte(len_w, hdr_idx_q[1:0], b);
            end
            tag_d = tag_w;
            len_d = len_w;
            if (hdr_idx_q == 3'd7) begin
              hdr_idx_d = 3'd0;
              if (tag_w == rwhp_pkg::TAG_FMT && len_w < rwhp_pkg::FMT_MIN_LEN) begin
                kind_d     = rwhp_pkg::KIND_FMT;
                err_code_d = rwhp_pkg::ST_TRUNC;
                err_seen_d = 1'b1;
              end else begin
                if (tag_w == rwhp_pkg::TAG_FMT) begin
                  kind_d     = rwhp_pkg::KIND_FMT;
                  fmt_pos_d  = 5'd0;
                  fmt_seen_d = 1'b1;
                end else if (tag_w == rwhp_pkg::TAG_DATA) begin
                  kind_d       = rwhp_pkg::KIND_DATA;
                  data_start_d = pos_q + COUNT_BITS'(1);
                  data_len_d   = len_w;
                  data_seen_d  = 1'b1;
                end else begin
                  kind_d = rwhp_pkg::KIND_OTHER;
                end
                left_d  = len_w;
                phase_d = (len_w == 32'd0) ? rwhp_pkg::PH_HDR : rwhp_pkg::PH_PAY;
              end
            end else begin
              hdr_idx_d = hdr_idx_q + 3'd1;
            end
          end
          rwhp_pkg::PH_PAY: begin
            if (kind_q == rwhp_pkg::KIND_FMT) begin
              if (fmt_pos_q <= 5'd1) begin
                fmt_code_d = fmt_pos_q[0] ? {b, fmt_code_q[7:0]} : {fmt_code_q[15:8], b};
              end else if (fmt_pos_q <= 5'd3) begin
                chan_d = fmt_pos_q[0] ? {b, chan_q[7:0]} : {chan_q[15:8], b};
              end else if (fmt_pos_q <= 5'd7) begin
                rate_d = rwhp_pkg::put_byte(rate_q, fmt_pos_q[1:0], b);
              end else if (fmt_pos_q == 5'd14 || fmt_pos_q == 5'd15) begin
                bits_d = fmt_pos_q[0] ? {b, bits_q[7:0]} : {bits_q[15:8], b};
              end
              if (fmt_pos_q < 5'd16) begin
                fmt_pos_d = fmt_pos_q + 5'd1;
              end
            end
            left_d = left_dec;
            if (left_dec == 32'd0) begin
              phase_d = len_q[0] ? rwhp_pkg::PH_PAD : rwhp_pkg::PH_HDR;
            end
          end
          rwhp_pkg::PH_PAD: begin
            phase_d   = rwhp_pkg::PH_HDR;
            hdr_idx_d = 3'd0;
          end
          default: begin
            phase_d   = rwhp_pkg::PH_HDR;
            hdr_idx_d = 3'd0;
          end
        endcase
      end
    end

    if (err_seen_d) begin
      status = err_code_d;
    end else if (phase_d != rwhp_pkg::PH_HDR) begin
      status = rwhp_pkg::ST_TRUNC;
    end else if (!fmt_seen_d || !data_seen_d) begin
      status = rwhp_pkg::ST_MISSING;
    end else if (fmt_code_d != rwhp_pkg::FORMAT_PCM || chan_d != exp_channels_q ||
                 rate_d != exp_rate_q || bits_d != exp_bits_q || data_len_d[0]) begin
      status = rwhp_pkg::ST_UNSUP;
    end else begin
      status = rwhp_pkg::ST_OK;
    end

    res_d        = res_q;
    res_d.status = status;
    if (status == rwhp_pkg::ST_OK) begin
      res_d.pay_offset   = 32'(data_start_d);
      res_d.pay_length   = data_len_d;
      res_d.channels     = chan_d;
      res_d.rate_hz      = rate_d;
      res_d.sample_width = bits_d;
    end else begin
      res_d.pay_offset   = 32'd0;
      res_d.pay_length   = 32'd0;
      res_d.channels     = 16'd0;
      res_d.rate_hz      = 32'd0;
      res_d.sample_width = 16'd0;
    end
    if (!last_xfer) begin
      res_d = res_q;
    end

    if (last_xfer) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      phase_q      <= rwhp_pkg::PH_FILE;
      hdr_idx_q    <= 3'd0;
      tag_q        <= 32'd0;
      len_q        <= 32'd0;
      left_q       <= 32'd0;
      fmt_pos_q    <= 5'd0;
      kind_q       <= rwhp_pkg::KIND_OTHER;
      fmt_code_q   <= 16'd0;
      chan_q       <= 16'd0;
      rate_q       <= 32'd0;
      bits_q       <= 16'd0;
      fmt_seen_q   <= 1'b0;
      data_seen_q  <= 1'b0;
      data_start_q <= '0;
      data_len_q   <= 32'd0;
      err_code_q   <= rwhp_pkg::ST_OK;
      err_seen_q   <= 1'b0;
      magic_bad_q  <= 1'b0;
      m_valid_q    <= 1'b0;
    end else if (last_xfer) begin
      pos_q        <= '0;
      phase_q      <= rwhp_pkg::PH_FILE;
      hdr_idx_q    <= 3'd0;
      tag_q        <= 32'd0;
      len_q        <= 32'd0;
      left_q       <= 32'd0;
      fmt_pos_q    <= 5'd0;
      kind_q       <= rwhp_pkg::KIND_OTHER;
      fmt_code_q   <= 16'd0;
      chan_q       <= 16'd0;
      rate_q       <= 32'd0;
      bits_q       <= 16'd0;
      fmt_seen_q   <= 1'b0;
      data_seen_q  <= 1'b0;
      data_start_q <= '0;
      data_len_q   <= 32'd0;
      err_code_q   <= rwhp_pkg::ST_OK;
      err_seen_q   <= 1'b0;
      magic_bad_q  <= 1'b0;
      m_valid_q    <= m_valid_d;
    end else begin
      pos_q        <= pos_d;
      phase_q      <= phase_d;
      hdr_idx_q    <= hdr_idx_d;
      tag_q        <= tag_d;
      len_q        <= len_d;
      left_q       <= left_d;
      fmt_pos_q    <= fmt_pos_d;
      kind_q       <= kind_d;
      fmt_code_q   <= fmt_code_d;
      chan_q       <= chan_d;
      rate_q       <= rate_d;
      bits_q       <= bits_d;
      fmt_seen_q   <= fmt_seen_d;
      data_seen_q  <= data_seen_d;
      data_start_q <= data_start_d;
      data_len_q   <= data_len_d;
      err_code_q   <= err_code_d;
      err_seen_q   <= err_seen_d;
      magic_bad_q  <= magic_bad_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(rwhp_pkg::OUT_TDATA_W - rwhp_pkg::OUT_BITS)'(0), res_q};

  `RWHP_ASSERT_NEXT(a_last_gives_result, clk_i, rst_ni, last_xfer, m_valid_q,
                    "A last byte did not load the result register.")
  `RWHP_ASSERT_NEXT(a_last_clears_parse, clk_i, rst_ni, last_xfer,
                    phase_q == rwhp_pkg::PH_FILE && pos_q == '0 && !err_seen_q,
                    "Parse state was not cleared after a last byte.")
  `RWHP_ASSERT_NOW(a_fail_fields_zero, clk_i, rst_ni,
                   m_valid_q && res_q.status != rwhp_pkg::ST_OK,
                   res_q.pay_offset == 32'd0 && res_q.pay_length == 32'd0 &&
                   res_q.channels == 16'd0 && res_q.rate_hz == 32'd0 &&
                   res_q.sample_width == 16'd0,
                   "Result fields are not zero on a failing status.")
  `RWHP_ASSERT_NEXT(a_error_sticky, clk_i, rst_ni, err_seen_q && !last_xfer,
                    err_seen_q && $stable(err_code_q) && $stable(phase_q),
                    "A latched error changed before the last byte.")

endmodule
